// ===== hdl/brpd_pkg.sv =====
// ----------------------------------------------------------------------------
// brpd_pkg
// Shared types and constants of the BMP RLE8/RLE4 palette decoder.
// ----------------------------------------------------------------------------
package brpd_pkg;

  localparam int unsigned DEFAULT_PALETTE_DEPTH = 256;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 168;
  localparam int unsigned COLOR_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MODE  = 2'd2;

  localparam logic [7:0] ESC_END_OF_LINE   = 8'h00;
  localparam logic [7:0] ESC_END_OF_BITMAP = 8'h01;
  localparam logic [7:0] ESC_DELTA         = 8'h02;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [3:0] NIBBLE_MASK  = 4'hf;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_DECODE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_DELTA  = 2'd1,
    PH_ABS    = 2'd2,
    PH_END    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [7:0]         first_byte;
    logic [7:0]         second_byte;
    logic [7:0]         palette_index;
    logic [COLOR_W-1:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic               wr_en;
    logic [7:0]         wr_idx;
    logic [COLOR_W-1:0] wr_color;
    logic               rd_en;
    logic [7:0]         rd_idx;
  } pal_req_t;

  typedef struct packed {
    logic [15:0]      out_row;
    logic [15:0]      out_column;
    logic [3:0][31:0] pixel;
    logic [3:0]       pixel_mask;
    logic             last_of_run;
  } grp_t;

endpackage

// ===== hdl/brpd_palette.sv =====
// ----------------------------------------------------------------------------
// brpd_palette
// Palette memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module brpd_palette #(
  parameter int unsigned Depth = brpd_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                              clk_i,
  input  brpd_pkg::pal_req_t                req_i,
  output logic [brpd_pkg::COLOR_W-1:0]      color_o
);
  import brpd_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [8:0] IdxLimit = 9'(Depth);

  logic [COLOR_W-1:0] mem_q [Depth];
  logic [COLOR_W-1:0] rd_data_q;
  logic               rd_out_q;
  logic               wr_in_range;
  logic               rd_in_range;

  assign wr_in_range = {1'b0, req_i.wr_idx} < IdxLimit;
  assign rd_in_range = {1'b0, req_i.rd_idx} < IdxLimit;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_in_range) begin
      mem_q[req_i.wr_idx[AddrW-1:0]] <= req_i.wr_color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_idx[AddrW-1:0]];
      rd_out_q  <= !rd_in_range;
    end
  end

  // An index beyond the palette reads as black.
  assign color_o = rd_out_q ? '0 : rd_data_q;

endmodule

// ===== hdl/brpd_seq.sv =====
// ----------------------------------------------------------------------------
// brpd_seq
// Code pair sequencer: position state, palette lookups and group expansion.
// ----------------------------------------------------------------------------
module brpd_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [brpd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  brpd_pkg::in_item_t                in_item_i,
  output brpd_pkg::pal_req_t                pal_req_o,
  input  logic [brpd_pkg::COLOR_W-1:0]      pal_color_i,
  output logic                              grp_valid_o,
  input  logic                              grp_ready_i,
  output brpd_pkg::grp_t                    grp_o
);
  import brpd_pkg::*;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    sat16 = v[16] ? 16'hffff : v[15:0];
  endfunction

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic                  nibble_q;
  logic [15:0]           col_q, col_d;
  logic [15:0]           row_q, row_d;
  logic [7:0]            abs_left_q, abs_left_d;
  logic [3:0][7:0]       idx_q, idx_d;
  logic [1:0]            lk_cnt_q, lk_cnt_d;
  logic [1:0]            lk_last_q, lk_last_d;
  logic [7:0]            rem_q, rem_d;
  logic [16:0]           grp_col_q, grp_col_d;
  logic                  run_q, run_d;
  logic                  rd_v_q;
  logic [1:0]            rd_slot_q;
  logic [3:0][COLOR_W-1:0] color_q;

  logic        accept;
  logic        is_decode;
  logic        work_go;
  logic [2:0]  per_pair;
  logic [2:0]  n_abs;
  logic [7:0]  col_add;
  logic [7:0]  row_add;
  logic [16:0] col_sum;
  logic [16:0] row_sum;
  logic [7:0]  b0, b1;
  logic [2:0]  grp_n;
  logic        grp_last;
  logic        grp_fire;

  assign b0        = in_item_i.first_byte;
  assign b1        = in_item_i.second_byte;
  assign accept    = in_valid_i && in_ready_o;
  assign is_decode = in_item_i.operation == OP_DECODE;
  assign per_pair  = nibble_q ? 3'd4 : 3'd2;
  assign n_abs     = (abs_left_q < {5'd0, per_pair}) ? abs_left_q[2:0] : per_pair;
  assign work_go   = is_decode &&
                     (((phase_q == PH_ABS) && (n_abs != 3'd0)) ||
                      ((phase_q == PH_NORMAL) && (b0 != 8'd0)));

  assign col_add = (phase_q == PH_ABS) ? {5'd0, n_abs} : b0;
  assign row_add = (phase_q == PH_DELTA) ? b1 : 8'd1;
  assign col_sum = {1'b0, col_q} + {9'd0, col_add};
  assign row_sum = {1'b0, row_q} + {9'd0, row_add};

  assign grp_n    = (rem_q >= 8'd4) ? 3'd4 : rem_q[2:0];
  assign grp_last = rem_q <= 8'd4;
  assign grp_fire = grp_valid_o && grp_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && work_go) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lk_cnt_q == lk_last_q) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (grp_fire && grp_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o         = state_q == ST_IDLE;
    grp_valid_o        = state_q == ST_EMIT;
    pal_req_o.wr_en    = accept && (in_item_i.operation == OP_LOAD);
    pal_req_o.wr_idx   = in_item_i.palette_index;
    pal_req_o.wr_color = in_item_i.palette_color;
    pal_req_o.rd_en    = state_q == ST_LOOKUP;
    pal_req_o.rd_idx   = idx_q[lk_cnt_q];
  end

  always_comb begin
    phase_d    = phase_q;
    col_d      = col_q;
    row_d      = row_q;
    abs_left_d = abs_left_q;
    idx_d      = idx_q;
    lk_cnt_d   = lk_cnt_q;
    lk_last_d  = lk_last_q;
    rem_d      = rem_q;
    grp_col_d  = grp_col_q;
    run_d      = run_q;
    if (accept) begin
      lk_cnt_d  = 2'd0;
      grp_col_d = {1'b0, col_q};
      case (in_item_i.operation)
        OP_START: begin
          col_d      = '0;
          row_d      = '0;
          phase_d    = PH_NORMAL;
          abs_left_d = '0;
        end
        OP_DECODE: begin
          case (phase_q)
            PH_DELTA: begin
              col_d   = sat16(col_sum);
              row_d   = sat16(row_sum);
              phase_d = PH_NORMAL;
            end
            PH_ABS: begin
              if (n_abs == 3'd0) begin
                phase_d = PH_NORMAL;
              end else begin
                col_d      = sat16(col_sum);
                abs_left_d = abs_left_q - {5'd0, n_abs};
                if (abs_left_q == {5'd0, n_abs}) begin
                  phase_d = PH_NORMAL;
                end
                rem_d = {5'd0, n_abs};
                run_d = 1'b0;
                if (nibble_q) begin
                  idx_d     = {{4'd0, b1[3:0]}, {4'd0, b1[7:4]},
                               {4'd0, b0[3:0]}, {4'd0, b0[7:4]}};
                  lk_last_d = 2'd3;
                end else begin
                  idx_d     = {8'd0, 8'd0, b1, b0};
                  lk_last_d = 2'd1;
                end
              end
            end
            PH_NORMAL: begin
              if (b0 == 8'd0) begin
                case (b1)
                  ESC_END_OF_LINE: begin
                    col_d = '0;
                    row_d = sat16(row_sum);
                  end
                  ESC_END_OF_BITMAP: begin
                    phase_d = PH_END;
                  end
                  ESC_DELTA: begin
                    phase_d = PH_DELTA;
                  end
                  default: begin
                    abs_left_d = b1;
                    phase_d    = PH_ABS;
                  end
                endcase
              end else begin
                col_d = sat16(col_sum);
                rem_d = b0;
                run_d = 1'b1;
                if (nibble_q) begin
                  idx_d     = {8'd0, 8'd0, {4'd0, b1[3:0]}, {4'd0, b1[7:4]}};
                  lk_last_d = 2'd1;
                end else begin
                  idx_d     = {8'd0, 8'd0, 8'd0, b1};
                  lk_last_d = 2'd0;
                end
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else if (state_q == ST_LOOKUP) begin
      lk_cnt_d = lk_cnt_q + 2'd1;
    end else if (grp_fire) begin
      rem_d     = rem_q - {5'd0, grp_n};
      grp_col_d = grp_col_q + 17'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_NORMAL;
      col_q      <= '0;
      row_q      <= '0;
      abs_left_q <= '0;
      width_q    <= CFG_DATA_W'(1);
      height_q   <= CFG_DATA_W'(1);
      nibble_q   <= 1'b0;
      rd_v_q     <= 1'b0;
      lk_cnt_q   <= '0;
      lk_last_q  <= '0;
      rem_q      <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      col_q      <= col_d;
      row_q      <= row_d;
      abs_left_q <= abs_left_d;
      rd_v_q     <= state_q == ST_LOOKUP;
      lk_cnt_q   <= lk_cnt_d;
      lk_last_q  <= lk_last_d;
      rem_q      <= rem_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          CFG_NIBBLE_MODE:  nibble_q <= cfg_data_i[0];
          default:          nibble_q <= nibble_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    grp_col_q <= grp_col_d;
    run_q     <= run_d;
    rd_slot_q <= lk_cnt_q;
    if (rd_v_q) begin
      color_q[rd_slot_q] <= pal_color_i;
    end
  end

  always_comb begin
    logic [17:0] pix_col;
    logic [1:0]  sel;
    logic        present;
    grp_o.out_row     = row_q;
    grp_o.out_column  = sat16(grp_col_q);
    grp_o.last_of_run = grp_last;
    for (int i = 0; i < 4; i++) begin
      pix_col = {1'b0, grp_col_q} + 18'(i);
      present = (3'(i) < grp_n) && (pix_col < {5'd0, width_q}) &&
                (row_q < {3'd0, height_q});
      if (!run_q) begin
        sel = 2'(i);
      end else if (nibble_q) begin
        sel = {1'b0, 1'(i)};
      end else begin
        sel = 2'd0;
      end
      grp_o.pixel_mask[i] = present;
      grp_o.pixel[i]      = present ? {ALPHA_OPAQUE, color_q[sel]} : '0;
    end
  end

endmodule

// ===== hdl/bmp_rle_palette_decoder_core.sv =====
// ----------------------------------------------------------------------------
// bmp_rle_palette_decoder_core
// Decodes BMP RLE8/RLE4 code pairs into groups of four BGRA pixels.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake             Content
// s_axis     in   tvalid/tready         operation, code pair, palette load
// m_axis     out  tvalid/tready/tlast   groups of four pixels per run or pair
// cfg        in   cfg_we_i              image_width, image_height, nibble_mode
//
// Loads, starts, escapes and deltas make no palette read and emit no group.
// A run makes L palette reads, then emits ceil(count/4) groups; an absolute pair
// makes L reads and emits one group. L is 1 or 2 for runs, 2 or 4 for absolute
// data, via the palette's single read port; input stalls until the last group.
// Reset clears position and phase; the palette is undefined until loaded.
// A stalled output holds in the output register while one more group waits.
// ----------------------------------------------------------------------------
module bmp_rle_palette_decoder_core #(
  parameter int unsigned PaletteDepth = brpd_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brpd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [brpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // first_byte, second_byte, palette_index, palette_color
  input  logic [brpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [brpd_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_row, out_column, pixel_zero..pixel_three, pixel_mask, zero fill
  output logic [brpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);
  import brpd_pkg::*;

  in_item_t           in_item;
  pal_req_t           pal_req;
  logic [COLOR_W-1:0] pal_color;
  grp_t               grp;
  logic               grp_valid;
  logic               grp_ready;
  grp_t               out_grp_q;
  logic               out_valid_q;

  assign in_item.operation     = s_axis_tuser;
  assign in_item.first_byte    = s_axis_tdata[7:0];
  assign in_item.second_byte   = s_axis_tdata[15:8];
  assign in_item.palette_index = s_axis_tdata[23:16];
  assign in_item.palette_color = s_axis_tdata[47:24];

  brpd_palette #(
    .Depth (PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .req_i   (pal_req),
    .color_o (pal_color)
  );

  brpd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .pal_req_o   (pal_req),
    .pal_color_i (pal_color),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  assign grp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (grp_valid && grp_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_valid && grp_ready) begin
      out_grp_q <= grp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_grp_q.last_of_run;
  assign m_axis_tdata  = {4'd0, out_grp_q.pixel_mask,
                          out_grp_q.pixel[3], out_grp_q.pixel[2],
                          out_grp_q.pixel[1], out_grp_q.pixel[0],
                          out_grp_q.out_column, out_grp_q.out_row};

endmodule

// ===== test/bmp_rle_palette_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// bmp_rle_palette_decoder_checker
// Watches the configuration port and both streams of the decoder. Every
// accepted request is expanded into the pixel groups it should produce. Each
// group on the output stream is compared field by field with the oldest group
// still due. Mismatches and the number of groups still due go to the top.
// ----------------------------------------------------------------------------
module bmp_rle_palette_decoder_checker #(
  parameter int unsigned PaletteDepth = brpd_pkg::DEFAULT_PALETTE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [brpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // first_byte, second_byte, palette_index, palette_color
  input  logic [brpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [brpd_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_row, out_column, pixel_zero..pixel_three, pixel_mask, zero fill
  input  logic [brpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             m_axis_tlast,
  output int unsigned                      mismatches_o,
  output int unsigned                      groups_due_o
);
  import brpd_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned POS_MAX     = 32'h0000_ffff;

  logic [COLOR_W-1:0]    palette_mem [PaletteDepth];
  grp_t                  pixel_groups_due [$];
  int unsigned           col_pos;
  int unsigned           row_pos;
  phase_e                phase;
  logic [7:0]            abs_left;
  logic [CFG_DATA_W-1:0] width_px;
  logic [CFG_DATA_W-1:0] height_px;
  logic                  nibble_px;
  int unsigned           mismatch_total = 0;
  int unsigned           group_index = 0;

  assign mismatches_o = mismatch_total;

  function automatic int unsigned clip16(input int unsigned v);
    return (v > POS_MAX) ? POS_MAX : v;
  endfunction

  task automatic queue_pixel_group(input int unsigned col, input logic [3:0][7:0] idx,
                                   input int unsigned n, input logic last);
    grp_t        g;
    int unsigned i;
    int unsigned clipped;
    g = '0;
    clipped = clip16(col);
    g.out_row = row_pos[15:0];
    g.out_column = clipped[15:0];
    for (i = 0; i < 4; i++) begin
      if (i < n && col + i < width_px && row_pos < height_px) begin
        g.pixel[i] = {ALPHA_OPAQUE,
                      (idx[i] < PaletteDepth) ? palette_mem[idx[i]] : {COLOR_W{1'b0}}};
        g.pixel_mask[i] = 1'b1;
      end
    end
    g.last_of_run = last;
    pixel_groups_due.push_back(g);
  endtask

  task automatic expand_request(input logic [OP_W-1:0] op, input logic [7:0] b0, b1, pidx,
                                input logic [COLOR_W-1:0] color);
    logic [3:0][7:0] idx;
    int unsigned     per;
    int unsigned     n;
    int unsigned     groups;
    int unsigned     g;
    int unsigned     i;
    idx = '0;
    if (op == OP_LOAD) begin
      if (pidx < PaletteDepth) palette_mem[pidx] = color;
    end else if (op == OP_START) begin
      col_pos = 0;
      row_pos = 0;
      phase = PH_NORMAL;
      abs_left = '0;
    end else if (op == OP_DECODE && phase != PH_END) begin
      if (phase == PH_DELTA) begin
        col_pos = clip16(col_pos + b0);
        row_pos = clip16(row_pos + b1);
        phase = PH_NORMAL;
      end else if (phase == PH_ABS) begin
        per = nibble_px ? 4 : 2;
        n = (abs_left < per) ? abs_left : per;
        if (n == 0) begin
          phase = PH_NORMAL;
        end else begin
          if (nibble_px) begin
            idx[0] = {4'd0, b0[7:4]};
            idx[1] = {4'd0, b0[3:0]};
            idx[2] = {4'd0, b1[7:4]};
            idx[3] = {4'd0, b1[3:0]};
          end else begin
            idx[0] = b0;
            idx[1] = b1;
          end
          queue_pixel_group(col_pos, idx, n, 1'b1);
          col_pos = clip16(col_pos + n);
          abs_left = abs_left - n[7:0];
          if (abs_left == 0) phase = PH_NORMAL;
        end
      end else if (b0 == 8'd0) begin
        case (b1)
          ESC_END_OF_LINE: begin
            col_pos = 0;
            row_pos = clip16(row_pos + 1);
          end
          ESC_END_OF_BITMAP: phase = PH_END;
          ESC_DELTA:         phase = PH_DELTA;
          default: begin
            abs_left = b1;
            phase = PH_ABS;
          end
        endcase
      end else begin
        // In nibble mode the run alternates high and low nibble, high first.
        groups = (b0 + 3) / 4;
        for (g = 0; g < groups; g++) begin
          n = (b0 - 4 * g < 4) ? b0 - 4 * g : 4;
          for (i = 0; i < 4; i++) begin
            if (nibble_px) idx[i] = {4'd0, (i % 2 == 1) ? b1[3:0] : b1[7:4]};
            else idx[i] = b1;
          end
          queue_pixel_group(col_pos + 4 * g, idx, n, g + 1 == groups);
        end
        col_pos = clip16(col_pos + b0);
      end
    end
  endtask

  task automatic check_group();
    grp_t        got;
    grp_t        want;
    logic        bad;
    int unsigned i;
    got.out_row = m_axis_tdata[15:0];
    got.out_column = m_axis_tdata[31:16];
    for (i = 0; i < 4; i++) got.pixel[i] = m_axis_tdata[32 + 32 * i +: 32];
    got.pixel_mask = m_axis_tdata[163:160];
    got.last_of_run = m_axis_tlast;
    if (pixel_groups_due.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= MAX_REPORTS) begin
        $display("group %0d: none expected, got row %h column %h mask %h", group_index,
                 got.out_row, got.out_column, got.pixel_mask);
      end
    end else begin
      want = pixel_groups_due.pop_front();
      bad = (got.out_row !== want.out_row) || (got.out_column !== want.out_column) ||
            (got.pixel_mask !== want.pixel_mask) || (got.last_of_run !== want.last_of_run);
      for (i = 0; i < 4; i++) bad = bad || (got.pixel[i] !== want.pixel[i]);
      if (bad) begin
        mismatch_total++;
        if (mismatch_total <= MAX_REPORTS) begin
          $display("group %0d expected: row %h column %h pixels %h %h %h %h mask %h last %b",
                   group_index, want.out_row, want.out_column, want.pixel[0], want.pixel[1],
                   want.pixel[2], want.pixel[3], want.pixel_mask, want.last_of_run);
          $display("group %0d actual:   row %h column %h pixels %h %h %h %h mask %h last %b",
                   group_index, got.out_row, got.out_column, got.pixel[0], got.pixel[1],
                   got.pixel[2], got.pixel[3], got.pixel_mask, got.last_of_run);
        end
      end
    end
    group_index++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos = 0;
      row_pos = 0;
      phase = PH_NORMAL;
      abs_left = '0;
      width_px = 1;
      height_px = 1;
      nibble_px = 1'b0;
      pixel_groups_due.delete();
      groups_due_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_group();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_px = cfg_data_i;
          CFG_IMAGE_HEIGHT: height_px = cfg_data_i;
          CFG_NIBBLE_MODE:  nibble_px = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expand_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                       s_axis_tdata[23:16], s_axis_tdata[47:24]);
      end
      groups_due_o <= pixel_groups_due.size();
    end
  end

endmodule

// ===== test/bmp_rle_palette_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// bmp_rle_palette_decoder_core_tb
// Drives the decoder with palette loads, image starts and code pairs under
// bursty input and a stalling output. The palette is filled first, then a
// directed set covers the extremes and every escape, then random images run
// under several register settings. The checker beside the block predicts and
// compares every pixel group; this module gives the verdict.
// ----------------------------------------------------------------------------
module bmp_rle_palette_decoder_core_tb;
  import brpd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
  localparam int unsigned     SETTLE_CYCLES  = 32;
  localparam int unsigned     HOLD_CYCLES    = 400;
  localparam int unsigned     WATCHDOG_LIMIT = 5000;
  localparam int unsigned     RANDOM_ITEMS   = 200;
  localparam int unsigned     PHASES         = 6;
  localparam int unsigned     PAL_USED       = 64;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]        s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  int unsigned            mismatches;
  int unsigned            groups_due;
  int unsigned            burst_left = 0;
  int unsigned            items_sent = 0;
  int unsigned            idle_cycles = 0;
  logic                   nibble_now = 1'b0;
  logic                   hold_wanted = 1'b0;

  bmp_rle_palette_decoder_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  bmp_rle_palette_decoder_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches_o  (mismatches),
    .groups_due_o  (groups_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("bmp_rle_palette_decoder_core: mismatch");
      $finish;
    end
  end

  // The output side alternates between free flow and stall patterns, and
  // holds off once for a long stretch so that the block backs up.
  initial begin : sink
    int unsigned stretch_left;
    int unsigned duty;
    logic        held;
    stretch_left = 0;
    duty = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(8, 80);
        duty = $urandom_range(0, 3);
      end
      stretch_left--;
      case (duty)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Byte that may serve as a pixel index; in byte mode it stays within the
  // loaded part of the palette.
  function automatic logic [7:0] pixel_byte();
    return nibble_now ? 8'($urandom()) : 8'($urandom_range(0, PAL_USED - 1));
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic [7:0] b0, b1, pidx,
                       input logic [COLOR_W-1:0] color);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {color, pidx, b1, b0};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic decode_pair(input logic [7:0] b0, b1);
    offer(OP_DECODE, b0, b1, 8'($urandom()), 24'($urandom()));
  endtask

  task automatic load_color(input logic [7:0] idx, input logic [COLOR_W-1:0] color);
    offer(OP_LOAD, 8'($urandom()), 8'($urandom()), idx, color);
  endtask

  task automatic start_image();
    offer(OP_START, 8'($urandom()), 8'($urandom()), 8'($urandom()), 24'($urandom()));
  endtask

  task automatic send_absolute(input logic [7:0] count);
    int unsigned per;
    per = nibble_now ? 4 : 2;
    decode_pair(8'h00, count);
    repeat ((count + per - 1) / per) decode_pair(pixel_byte(), pixel_byte());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (groups_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] w, h, input logic nib);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_idx <= CFG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_idx <= CFG_NIBBLE_MODE;
    cfg_data <= {{(CFG_DATA_W - 1){1'b0}}, nib};
    @(posedge clk);
    cfg_we <= 1'b0;
    nibble_now = nib;
  endtask

  initial begin : stimulus
    int unsigned           i;
    int unsigned           ph;
    int unsigned           target;
    int unsigned           kind;
    int unsigned           pick;
    logic [7:0]            cnt;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_config(13'd16, 13'd8, 1'b0);
    for (i = 0; i < PAL_USED; i++) begin
      if (i == 0) load_color(8'(i), 24'h000000);
      else if (i == PAL_USED - 1) load_color(8'(i), 24'hffffff);
      else load_color(8'(i), 24'($urandom()));
    end

    start_image();
    decode_pair(8'd1, 8'h3f);
    decode_pair(8'd255, 8'h00);
    decode_pair(8'h00, ESC_END_OF_LINE);
    decode_pair(8'h00, ESC_DELTA);
    decode_pair(8'd3, 8'd1);
    send_absolute(8'd3);
    offer(OP_UNUSED, 8'hff, 8'hff, 8'hff, 24'hffffff);
    load_color(8'h2a, 24'h123456);
    decode_pair(8'd4, 8'h2a);
    decode_pair(8'h00, ESC_END_OF_BITMAP);
    decode_pair(8'd5, 8'd7);
    start_image();
    decode_pair(8'd6, 8'h31);
    write_config(13'd4096, 13'd4096, 1'b1);
    start_image();
    decode_pair(8'd5, 8'h3c);
    send_absolute(8'd5);
    decode_pair(8'd255, 8'ha5);
    write_config(13'd1, 13'd1, 1'b0);
    start_image();
    decode_pair(8'd8, 8'h11);
    decode_pair(8'h00, ESC_END_OF_LINE);
    decode_pair(8'd2, 8'h22);

    // Walk with large deltas toward the far corner of the largest image.
    write_config(13'd4096, 13'd4096, 1'b0);
    start_image();
    repeat (8) begin
      decode_pair(8'h00, ESC_DELTA);
      decode_pair(8'hff, 8'hff);
    end
    decode_pair(8'd9, 8'h3d);
    decode_pair(8'h00, ESC_END_OF_LINE);
    decode_pair(8'd3, 8'h3e);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_config(13'd4096, 13'd4096, 1'($urandom()));
      end else if (ph == 1) begin
        write_config(13'd1, 13'd1, 1'($urandom()));
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096)) : 13'($urandom_range(1, 48));
        h = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096)) : 13'($urandom_range(1, 10));
        write_config(w, h, 1'($urandom()));
      end
      if (ph == 2) hold_wanted = 1'b1;
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          start_image();
          repeat ($urandom_range(2, 10)) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
              pick = $urandom_range(0, 19);
              if (pick < 14) cnt = 8'($urandom_range(1, 16));
              else if (pick < 19) cnt = 8'($urandom_range(17, 64));
              else cnt = 8'($urandom_range(65, 255));
              decode_pair(cnt, pixel_byte());
            end else if (kind == 5) begin
              decode_pair(8'h00, ESC_END_OF_LINE);
            end else if (kind == 6) begin
              decode_pair(8'h00, ESC_DELTA);
              if ($urandom_range(0, 4) == 0) begin
                decode_pair(8'($urandom()), 8'($urandom()));
              end else begin
                decode_pair(8'($urandom_range(0, 15)), 8'($urandom_range(0, 3)));
              end
            end else if (kind < 9) begin
              if ($urandom_range(0, 9) == 0) send_absolute(8'($urandom_range(21, 255)));
              else send_absolute(8'($urandom_range(3, 20)));
            end else begin
              decode_pair(8'h00, ESC_END_OF_BITMAP);
              decode_pair(8'($urandom()), 8'($urandom()));
            end
          end
        end else begin
          repeat ($urandom_range(1, 6)) begin
            offer(2'($urandom()), pixel_byte(), pixel_byte(), 8'($urandom()),
                  24'($urandom()));
          end
        end
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("bmp_rle_palette_decoder_core: match");
    end else begin
      $display("bmp_rle_palette_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
